### design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ebtd_pkg.sv
// Shared types, character constants and classification helpers
// for the escaped byte token decoder. No dependencies.
package ebtd_pkg;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int LA_DEPTH = 5;
	localparam int LA_CNT_W = 3;

	localparam logic [1:0] ROLE_ADDR  = 2'd0;
	localparam logic [1:0] ROLE_CMD   = 2'd1;
	localparam logic [1:0] ROLE_PARAM = 2'd2;

	localparam logic [1:0] SKIP_NONE = 2'd0;
	localparam logic [1:0] SKIP_ONE  = 2'd1;
	localparam logic [1:0] SKIP_WS   = 2'd2;

	localparam logic [13:0] DEC_MAX = 14'd255;

	typedef struct packed {
		logic [7:0] char_in;
		logic       msg_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic [1:0] token_role;
		logic       msg_done;
		logic       burst_end;
	} res_t;

	// stack entry: inner marks replayed held whitespace
	typedef struct packed {
		logic       inner;
		logic [7:0] ch;
	} stk_ent_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

endpackage

### design/ebtd_intf.sv
// Word channels of the decoder: character input and token output.
// Payload types follow ebtd_pkg field widths.
interface ebtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       msg_last;
	modport source(output valid, char_in, msg_last, input ready);
	modport sink(input valid, char_in, msg_last, output ready);
endinterface

interface ebtd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_byte;
	logic [1:0] token_role;
	logic       msg_done;
	logic       burst_end;
	modport source(output valid, token_byte, token_role, msg_done, burst_end, input ready);
	modport sink(input valid, token_byte, token_role, msg_done, burst_end, output ready);
endinterface

### design/ebtd_fifo.sv
// Two-entry word queue with registered storage.
// Used between front and back end and on the output side.
module ebtd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

endmodule

### design/ebtd_front.sv
// Front end: takes character words, tracks message length and
// drops one-character messages. Depends on ebtd_pkg, ebtd_intf.
module ebtd_front (
	input  logic               clk,
	input  logic               arst_n,
	ebtd_in_if.sink            in_ch,
	output logic               push,
	output ebtd_pkg::in_word_t word,
	input  logic               space
);

	logic [1:0] seen_q;
	logic       acc;

	assign in_ch.ready   = space;
	assign acc           = in_ch.valid && space;
	assign word.char_in  = in_ch.char_in;
	assign word.msg_last = in_ch.msg_last;
	// a message that ends on its first character decodes to nothing
	assign push          = acc && !(in_ch.msg_last && seen_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
		end else if (acc) begin
			if (in_ch.msg_last) seen_q <= 2'd0;
			else if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
		end
	end

endmodule

### design/ebtd_back.sv
// Back end: escape decoding sequencer with lookahead, replay stack and
// whitespace hold memory. Depends on ebtd_pkg.
module ebtd_back #(
	parameter int HOLD_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mid_valid,
	output logic               mid_ready,
	input  ebtd_pkg::in_word_t mid_data,
	output logic               out_push,
	input  logic               out_full,
	output ebtd_pkg::res_t     out_data
);

	localparam int STK_DEPTH = HOLD_DEPTH + 32;
	localparam int SP_W      = $clog2(STK_DEPTH + 1);
	localparam int SA_W      = $clog2(STK_DEPTH);
	localparam int HC_W      = $clog2(HOLD_DEPTH + 1);
	localparam int HA_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int LW        = ebtd_pkg::LA_CNT_W;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_EXEC   = 10'b0000000010,
		ST_DECIDE = 10'b0000000100,
		ST_GET    = 10'b0000001000,
		ST_LOAD   = 10'b0000010000,
		ST_REL_RD = 10'b0000100000,
		ST_REL_WR = 10'b0001000000,
		ST_REFEED = 10'b0010000000,
		ST_FINAL  = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} bk_state_t;

	bk_state_t           state_q;
	ebtd_pkg::stk_ent_t  cur_q;
	logic                end_q;
	logic                de_q;
	logic [7:0]          la_q [ebtd_pkg::LA_DEPTH];
	logic [7:0]          la_sh [ebtd_pkg::LA_DEPTH];
	logic [LW-1:0]       la_cnt_q;
	logic [LW-1:0]       ri_q;
	logic [1:0]          tidx_q;
	logic [1:0]          tidx_n;
	logic [1:0]          skip_q;
	logic [1:0]          skip_nxt;
	logic                dsn_q;
	logic [HC_W-1:0]     held_cnt_q;
	logic [HC_W-1:0]     rel_q;
	logic                dly_v_q;
	logic [7:0]          dly_b_q;
	logic [1:0]          dly_r_q;
	logic                pend_v_q;
	ebtd_pkg::res_t      pend_q;
	logic [SP_W-1:0]     sp_q;
	ebtd_pkg::stk_ent_t  stk_mem [STK_DEPTH];
	ebtd_pkg::stk_ent_t  stk_rd_q;
	logic [7:0]          held_mem [HOLD_DEPTH];
	logic [7:0]          hrd_q;

	// character step
	logic [7:0]          c;
	logic                ws;
	logic                skip_eat;
	logic                hold_it;
	logic                hold_room;
	logic                la_app;

	// stack port
	logic                stk_we;
	ebtd_pkg::stk_ent_t  stk_wd;
	logic [SA_W-1:0]     stk_wa;
	logic [SA_W-1:0]     stk_ra;
	logic [HA_W-1:0]     held_wa;
	logic [HA_W-1:0]     held_ra;

	// token decision
	logic                dec_hit;
	logic [7:0]          dec_tok;
	logic [LW-1:0]       drp;
	logic                dec_rf;
	logic                dec_sk1;
	logic                dec_dsn;
	logic                try_dec;
	logic                two;
	logic [3:0]          d1, d2, d3, d4;
	logic [LW-1:0]       kc;
	logic [6:0]          p2;
	logic [9:0]          p3;
	logic [13:0]         p4;
	logic [13:0]         v;
	logic [7:0]          vpre;
	logic                res_blk;
	logic                dec_go;
	logic                fin_go;
	logic                new_res;

	assign c         = cur_q.ch;
	assign ws        = ebtd_pkg::is_ws(c);
	assign skip_eat  = (skip_q == ebtd_pkg::SKIP_WS && ws) ||
	                   (skip_q == ebtd_pkg::SKIP_ONE && c == ebtd_pkg::CH_SPACE);
	assign skip_nxt  = (skip_q == ebtd_pkg::SKIP_WS && ws) ? ebtd_pkg::SKIP_WS
	                                                       : ebtd_pkg::SKIP_NONE;
	assign hold_it   = dsn_q && !cur_q.inner && ws;
	assign hold_room = held_cnt_q < HC_W'(HOLD_DEPTH);
	assign la_app    = !skip_eat && !hold_it && held_cnt_q == '0 &&
	                   la_cnt_q < LW'(ebtd_pkg::LA_DEPTH);
	assign tidx_n    = (tidx_q == ebtd_pkg::ROLE_PARAM) ? tidx_q : tidx_q + 2'd1;

	assign stk_wa  = SA_W'(sp_q);
	assign stk_ra  = SA_W'(sp_q - SP_W'(1));
	assign held_wa = HA_W'(held_cnt_q);
	assign held_ra = HA_W'(rel_q - HC_W'(1));

	assign res_blk = pend_v_q && out_full;
	assign dec_go  = dec_hit && !(dly_v_q && res_blk);
	assign fin_go  = !(dly_v_q && res_blk);
	assign new_res = dly_v_q && ((state_q == ST_DECIDE && dec_go) ||
	                             (state_q == ST_FINAL && fin_go));

	assign mid_ready = (state_q == ST_IDLE);
	assign out_push  = (new_res && pend_v_q) ||
	                   (state_q == ST_DONE && pend_v_q && !out_full);
	always_comb begin
		out_data           = pend_q;
		out_data.burst_end = (state_q == ST_DONE);
	end

	// stack write source
	always_comb begin
		stk_we = 1'b0;
		stk_wd = cur_q;
		case (state_q)
			ST_EXEC: begin
				stk_we = !skip_eat && ((hold_it && !hold_room) ||
				                       (!hold_it && held_cnt_q != '0));
			end
			ST_REL_WR: begin
				stk_we       = 1'b1;
				stk_wd.inner = 1'b1;
				stk_wd.ch    = hrd_q;
			end
			ST_REFEED: begin
				stk_we       = 1'b1;
				stk_wd.inner = 1'b0;
				stk_wd.ch    = la_q[ri_q - LW'(1)];
			end
			default: begin
				stk_we = 1'b0;
			end
		endcase
	end

	// decimal digit run and its value
	always_comb begin
		d1 = la_q[1][3:0];
		d2 = la_q[2][3:0];
		d3 = la_q[3][3:0];
		d4 = la_q[4][3:0];
		kc = '0;
		if (la_cnt_q > LW'(1) && ebtd_pkg::is_dec(la_q[1])) begin
			kc = LW'(1);
			if (la_cnt_q > LW'(2) && ebtd_pkg::is_dec(la_q[2])) begin
				kc = LW'(2);
				if (la_cnt_q > LW'(3) && ebtd_pkg::is_dec(la_q[3])) begin
					kc = LW'(3);
					if (la_cnt_q > LW'(4) && ebtd_pkg::is_dec(la_q[4])) kc = LW'(4);
				end
			end
		end
		p2 = 7'(d1) * 7'd10 + 7'(d2);
		p3 = 10'(p2) * 10'd10 + 10'(d3);
		p4 = 14'(p3) * 14'd10 + 14'(d4);
		case (kc)
			LW'(1):  v = 14'(d1);
			LW'(2):  v = 14'(p2);
			LW'(3):  v = 14'(p3);
			default: v = p4;
		endcase
		vpre = (kc == LW'(4)) ? p3[7:0] : 8'(p2);
	end

	// one token decision on the lookahead
	always_comb begin
		dec_hit = 1'b0;
		dec_tok = la_q[0];
		drp     = LW'(1);
		dec_rf  = 1'b0;
		dec_sk1 = 1'b0;
		dec_dsn = 1'b0;
		try_dec = 1'b0;
		two     = 1'b0;
		if (la_cnt_q != '0) begin
			if (la_q[0] != ebtd_pkg::CH_BSL) begin
				dec_hit = 1'b1;
			end else if (la_cnt_q == LW'(1)) begin
				if (de_q) begin
					dec_hit = 1'b1;
					dec_tok = ebtd_pkg::CH_BSL;
				end
			end else begin
				try_dec = 1'b1;
				if (la_q[1] == ebtd_pkg::CH_ZERO) begin
					if (la_cnt_q == LW'(2) && !de_q) begin
						try_dec = 1'b0;
					end else if (la_cnt_q >= LW'(3) && la_q[2] == ebtd_pkg::CH_X) begin
						if (la_cnt_q == LW'(3) && !de_q) begin
							try_dec = 1'b0;
						end else if (la_cnt_q >= LW'(4)) begin
							try_dec = 1'b0;
							if (!ebtd_pkg::is_hex(la_q[3])) begin
								dec_hit = 1'b1;
								dec_tok = ebtd_pkg::CH_BSL;
							end else if (la_cnt_q != LW'(4) || de_q) begin
								two     = la_cnt_q == LW'(5) && ebtd_pkg::is_hex(la_q[4]);
								dec_hit = 1'b1;
								dec_tok = two ? {ebtd_pkg::hex_val(la_q[3]),
								                 ebtd_pkg::hex_val(la_q[4])}
								              : {4'h0, ebtd_pkg::hex_val(la_q[3])};
								drp     = two ? LW'(5) : LW'(4);
								dec_rf  = 1'b1;
								dec_sk1 = 1'b1;
							end
						end
					end
				end
				if (try_dec && !(kc < LW'(4) && kc + LW'(1) == la_cnt_q && !de_q)) begin
					dec_hit = 1'b1;
					if (kc == '0) begin
						dec_tok = ebtd_pkg::CH_BSL;
					end else begin
						dec_rf = 1'b1;
						if (v > ebtd_pkg::DEC_MAX) begin
							// last digit goes back as a literal
							dec_tok = vpre;
							drp     = kc;
						end else begin
							dec_tok = v[7:0];
							drp     = kc + LW'(1);
							dec_dsn = 1'b1;
						end
					end
				end
			end
		end
	end

	// lookahead after dropping the decided characters
	always_comb begin
		for (int i = 0; i < ebtd_pkg::LA_DEPTH; i++) begin
			la_sh[i] = la_q[i];
			if (LW'(i) + drp < LW'(ebtd_pkg::LA_DEPTH)) la_sh[i] = la_q[LW'(i) + drp];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_q      <= 1'b0;
			de_q       <= 1'b0;
			la_cnt_q   <= '0;
			ri_q       <= '0;
			tidx_q     <= ebtd_pkg::ROLE_ADDR;
			skip_q     <= ebtd_pkg::SKIP_NONE;
			dsn_q      <= 1'b0;
			held_cnt_q <= '0;
			rel_q      <= '0;
			dly_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			sp_q       <= '0;
		end else begin
			if (stk_we) sp_q <= sp_q + SP_W'(1);
			else if (state_q == ST_GET && sp_q != '0) sp_q <= sp_q - SP_W'(1);
			case (state_q)
				ST_IDLE: begin
					if (mid_valid) begin
						end_q   <= mid_data.msg_last;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					skip_q <= skip_nxt;
					if (skip_eat) begin
						state_q <= ST_GET;
					end else if (hold_it && hold_room) begin
						held_cnt_q <= held_cnt_q + HC_W'(1);
						state_q    <= ST_GET;
					end else if (hold_it || held_cnt_q != '0) begin
						rel_q   <= held_cnt_q;
						state_q <= ST_REL_RD;
					end else begin
						if (la_app) la_cnt_q <= la_cnt_q + LW'(1);
						de_q    <= 1'b0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!dec_hit) begin
						state_q <= de_q ? ST_FINAL : ST_GET;
					end else if (dec_go) begin
						dly_v_q  <= 1'b1;
						tidx_q   <= tidx_n;
						if (dly_v_q) pend_v_q <= 1'b1;
						la_cnt_q <= la_cnt_q - drp;
						if (dec_sk1) skip_q <= ebtd_pkg::SKIP_ONE;
						if (dec_dsn) begin
							skip_q <= ebtd_pkg::SKIP_WS;
							dsn_q  <= 1'b1;
						end
						if (dec_rf) begin
							ri_q    <= la_cnt_q - drp;
							state_q <= (la_cnt_q == drp) ? ST_GET : ST_REFEED;
						end
					end
				end
				ST_REFEED: begin
					ri_q <= ri_q - LW'(1);
					if (ri_q == LW'(1)) begin
						la_cnt_q <= '0;
						state_q  <= ST_GET;
					end
				end
				ST_GET: begin
					if (sp_q != '0) begin
						state_q <= ST_LOAD;
					end else if (end_q) begin
						held_cnt_q <= '0;
						de_q       <= 1'b1;
						state_q    <= ST_DECIDE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_LOAD: begin
					state_q <= ST_EXEC;
				end
				ST_REL_RD: begin
					state_q <= ST_REL_WR;
				end
				ST_REL_WR: begin
					rel_q <= rel_q - HC_W'(1);
					if (rel_q == HC_W'(1)) begin
						held_cnt_q <= '0;
						state_q    <= ST_GET;
					end else begin
						state_q <= ST_REL_RD;
					end
				end
				ST_FINAL: begin
					if (fin_go) begin
						if (dly_v_q) pend_v_q <= 1'b1;
						dly_v_q    <= 1'b0;
						tidx_q     <= ebtd_pkg::ROLE_ADDR;
						skip_q     <= ebtd_pkg::SKIP_NONE;
						dsn_q      <= 1'b0;
						held_cnt_q <= '0;
						la_cnt_q   <= '0;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!out_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_ra];
		hrd_q    <= held_mem[held_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (state_q == ST_IDLE && mid_valid) begin
			cur_q.inner <= 1'b0;
			cur_q.ch    <= mid_data.char_in;
		end
		if (state_q == ST_LOAD) cur_q <= stk_rd_q;
		if (state_q == ST_EXEC) begin
			if (!skip_eat && hold_it && hold_room) held_mem[held_wa] <= c;
			if (la_app) la_q[la_cnt_q] <= c;
		end
		if (state_q == ST_DECIDE && dec_go) begin
			la_q    <= la_sh;
			dly_b_q <= dec_tok;
			dly_r_q <= tidx_q;
			if (dly_v_q) begin
				pend_q.token_byte <= dly_b_q;
				pend_q.token_role <= dly_r_q;
				pend_q.msg_done   <= 1'b0;
				pend_q.burst_end  <= 1'b0;
			end
		end
		if (state_q == ST_FINAL && fin_go && dly_v_q) begin
			pend_q.token_byte <= dly_b_q;
			pend_q.token_role <= dly_r_q;
			pend_q.msg_done   <= 1'b1;
			pend_q.burst_end  <= 1'b0;
		end
	end

endmodule

### design/escaped_byte_token_decoder.sv
// Top level of the escaped byte token decoder.
// Depends on ebtd_pkg, ebtd_intf, ebtd_fifo, ebtd_front, ebtd_back.

// Turns message characters into byte tokens. Plain characters pass through;
// a backslash escape "\0x" with one or two hex digits yields that byte and
// eats one following space; a backslash with one to four decimal digits
// yields their value (above 255 the last digit comes back as a literal) and
// eats following whitespace, after which trailing whitespace of the message
// is held in a HOLD_DEPTH-entry memory and dropped at message end. The first
// token is tagged address, the second command, the rest parameters; the
// final token carries msg_done and the last word caused by an input carries
// burst_end. Sequencing: one input word is decoded at a time by the back-end
// sequencer. A plain character passes through take, step, emit, empty
// decision, stack check and flush; each character re-run from the replay
// stack adds a memory read, load and step, plus its decisions once it reaches
// the lookahead, each lookahead character put back on the stack adds a refeed
// step, and each released held whitespace character a hold memory read and a
// stack write. Waiting on a full output queue adds on top.
// The two-entry front queue takes the next word while the back end
// works, and the two-entry output queue decouples the token consumer.
// No clearing pass is needed after reset.
module escaped_byte_token_decoder #(
	parameter int HOLD_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ebtd_in_if.sink     in_ch,
	ebtd_out_if.source  out_ch
);

	localparam int IN_W  = $bits(ebtd_pkg::in_word_t);
	localparam int RES_W = $bits(ebtd_pkg::res_t);

	ebtd_pkg::in_word_t front_word;
	ebtd_pkg::in_word_t mid_word;
	logic               front_push;
	logic               mid_space;
	logic               mid_valid;
	logic               mid_ready;
	logic [IN_W-1:0]    mid_vec;

	ebtd_pkg::res_t     back_res;
	ebtd_pkg::res_t     out_word;
	logic               back_push;
	logic               out_space;
	logic [RES_W-1:0]   out_vec;

	// accept, count characters, drop single-character messages
	ebtd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.push   (front_push),
		.word   (front_word),
		.space  (mid_space)
	);

	// decouples acceptance from decoding
	ebtd_fifo #(
		.WIDTH (IN_W)
	) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_push),
		.wr_ready (mid_space),
		.wr_data  (front_word),
		.rd_valid (mid_valid),
		.rd_ready (mid_ready),
		.rd_data  (mid_vec)
	);

	assign mid_word = mid_vec;

	// decode sequencer
	ebtd_back #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid_data  (mid_word),
		.out_push  (back_push),
		.out_full  (!out_space),
		.out_data  (back_res)
	);

	// registered output side
	ebtd_fifo #(
		.WIDTH (RES_W)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (back_push),
		.wr_ready (out_space),
		.wr_data  (back_res),
		.rd_valid (out_ch.valid),
		.rd_ready (out_ch.ready),
		.rd_data  (out_vec)
	);

	assign out_word          = out_vec;
	assign out_ch.token_byte = out_word.token_byte;
	assign out_ch.token_role = out_word.token_role;
	assign out_ch.msg_done   = out_word.msg_done;
	assign out_ch.burst_end  = out_word.burst_end;

endmodule

### design/ebtd_checker.sv
// Port-level checks on the decoder output stream, bound to the top level.
// Depends on ebtd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ebtd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] token_byte,
	input logic [1:0] token_role,
	input logic       msg_done,
	input logic       burst_end
);

	logic after_done_q;

	// set at reset and after each final token: next word opens a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_done_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			after_done_q <= msg_done;
		end
	end

	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output word dropped while stalled")
	`AST_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(token_byte) && $stable(token_role) && $stable(msg_done) && $stable(burst_end), "output word changed while stalled")
	`AST_IMPLY(a_done_burst, clk, arst_n, out_valid && msg_done, burst_end, "final token not last of its burst")
	`AST_IMPLY(a_first_addr, clk, arst_n, out_valid && after_done_q, token_role == ebtd_pkg::ROLE_ADDR, "message does not open with address")

endmodule

bind escaped_byte_token_decoder ebtd_checker u_ebtd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.token_byte (out_ch.token_byte),
	.token_role (out_ch.token_role),
	.msg_done   (out_ch.msg_done),
	.burst_end  (out_ch.burst_end)
);
